// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros shared by the escaper RTL.
// Both macros assume a clock named clk and an active-low reset named arst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle check: prop must hold at every edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Next-cycle check: cons must hold in the cycle after ante.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/cbe_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbe_pkg
// Types, constants and the short-escape table for the byte escaper.
// ---------------------------------------------------------------------------
package cbe_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int MASK_WORDS = 4;
	localparam int SEQ_LEN    = 4;

	typedef logic [7:0] char_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MASK_0   = 3'd0,
		REG_MASK_64  = 3'd1,
		REG_MASK_128 = 3'd2,
		REG_MASK_192 = 3'd3
	} cfg_reg_t;

	localparam logic [CFG_DATA_W-1:0] MASK_0_RST   = 64'hFFFF_FFFB_0000_0000;
	localparam logic [CFG_DATA_W-1:0] MASK_64_RST  = 64'h7FFF_FFFF_EFFF_FFFF;
	localparam logic [CFG_DATA_W-1:0] MASK_128_RST = 64'h0;
	localparam logic [CFG_DATA_W-1:0] MASK_192_RST = 64'h0;

	// Characters
	localparam char_t CHAR_NONE   = 8'h00;
	localparam char_t CHAR_BSP    = 8'h08;
	localparam char_t CHAR_TAB    = 8'h09;
	localparam char_t CHAR_LF     = 8'h0A;
	localparam char_t CHAR_FF     = 8'h0C;
	localparam char_t CHAR_CR     = 8'h0D;
	localparam char_t CHAR_DQUOTE = 8'h22;
	localparam char_t CHAR_ZERO   = 8'h30;
	localparam char_t CHAR_BSLASH = 8'h5C;
	localparam char_t CHAR_LC_B   = 8'h62;
	localparam char_t CHAR_LC_F   = 8'h66;
	localparam char_t CHAR_LC_N   = 8'h6E;
	localparam char_t CHAR_LC_R   = 8'h72;
	localparam char_t CHAR_LC_T   = 8'h74;

	// Escape sequence lengths, stored as length minus one
	localparam logic [1:0] LEN_COPY  = 2'd0;
	localparam logic [1:0] LEN_SHORT = 2'd1;
	localparam logic [1:0] LEN_OCTAL = 2'd3;

	// Encoded output sequence for one source byte
	typedef struct packed {
		logic [SEQ_LEN-1:0][7:0] chars;   // chars[0] goes out first
		logic [1:0]              len_m1;
		logic                    fin;
	} seq_t;

	// One output transaction payload
	typedef struct packed {
		char_t out_byte;
		logic  run_last;
		logic  string_end;
	} beat_t;

	// Serializer status, for checking
	typedef struct packed {
		logic       busy;
		logic [1:0] rem;
		logic       out_full;
	} ser_stat_t;

	// Second char of a two-char escape, CHAR_NONE if there is none
	function automatic char_t short_escape(input char_t b);
		char_t r;
		case (b)
			CHAR_BSP:    r = CHAR_LC_B;
			CHAR_FF:     r = CHAR_LC_F;
			CHAR_LF:     r = CHAR_LC_N;
			CHAR_CR:     r = CHAR_LC_R;
			CHAR_TAB:    r = CHAR_LC_T;
			CHAR_BSLASH: r = CHAR_BSLASH;
			CHAR_DQUOTE: r = CHAR_DQUOTE;
			default:     r = CHAR_NONE;
		endcase
		return r;
	endfunction

endpackage

// ----- hdl/cbe_channels.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbe channel interfaces
// Valid/ready channels for source bytes and escaped output bytes.
// ---------------------------------------------------------------------------
interface cbe_in_if
	import cbe_pkg::*;
();
	logic  valid;
	logic  ready;
	char_t in_byte;
	logic  final_byte;

	modport source (output valid, in_byte, final_byte, input ready);
	modport sink (input valid, in_byte, final_byte, output ready);
endinterface

interface cbe_out_if
	import cbe_pkg::*;
();
	logic  valid;
	logic  ready;
	char_t out_byte;
	logic  run_last;
	logic  string_end;

	modport source (output valid, out_byte, run_last, string_end, input ready);
	modport sink (input valid, out_byte, run_last, string_end, output ready);
endinterface

// ----- hdl/cbe_mask_regs.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbe_mask_regs
// 256-bit pass mask in four 64-bit registers, with per-byte lookup.
// ---------------------------------------------------------------------------
module cbe_mask_regs
	import cbe_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  char_t                 lookup_byte,
	output logic                  pass
);

	logic [MASK_WORDS-1:0][CFG_DATA_W-1:0] mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q[0] <= MASK_0_RST;
			mask_q[1] <= MASK_64_RST;
			mask_q[2] <= MASK_128_RST;
			mask_q[3] <= MASK_192_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MASK_0:   mask_q[0] <= cfg_data;
				REG_MASK_64:  mask_q[1] <= cfg_data;
				REG_MASK_128: mask_q[2] <= cfg_data;
				REG_MASK_192: mask_q[3] <= cfg_data;
				default: ;   // unmapped index, write dropped
			endcase
		end
	end

	assign pass = mask_q[lookup_byte[7:6]][lookup_byte[5:0]];

endmodule

// ----- hdl/cbe_encode.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbe_encode
// Turns one source byte into its escape sequence (1, 2 or 4 chars).
// ---------------------------------------------------------------------------
module cbe_encode
	import cbe_pkg::*;
(
	input  char_t in_byte,
	input  logic  final_byte,
	input  logic  pass,
	output seq_t  seq
);

	char_t esc;

	assign esc = short_escape(in_byte);

	always_comb begin
		seq.fin = final_byte;
		if (pass) begin
			seq.chars  = {CHAR_NONE, CHAR_NONE, CHAR_NONE, in_byte};
			seq.len_m1 = LEN_COPY;
		end else if (esc != CHAR_NONE) begin
			seq.chars  = {CHAR_NONE, CHAR_NONE, esc, CHAR_BSLASH};
			seq.len_m1 = LEN_SHORT;
		end else begin
			// backslash, then octal digits, most significant first
			seq.chars  = {CHAR_ZERO + {5'd0, in_byte[2:0]},
			              CHAR_ZERO + {5'd0, in_byte[5:3]},
			              CHAR_ZERO + {6'd0, in_byte[7:6]},
			              CHAR_BSLASH};
			seq.len_m1 = LEN_OCTAL;
		end
	end

endmodule

// ----- hdl/cbe_serializer.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbe_serializer
// Holds one encoded sequence and shifts it out one char per cycle, unless
// the output stalls, into a registered output stage.
// ---------------------------------------------------------------------------
module cbe_serializer
	import cbe_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  seq_t      seq,
	output logic      take_ok,
	output logic      out_valid,
	input  logic      out_ready,
	output beat_t     out_beat,
	output ser_stat_t stat
);

	logic                    busy_s1;
	logic [1:0]              rem_s1;
	logic [SEQ_LEN-1:0][7:0] chars_s1;
	logic                    fin_s1;
	logic                    valid_s2;
	beat_t                   beat_s2;
	logic                    adv;
	logic                    last;

	assign last    = (rem_s1 == 2'd0);
	assign adv     = busy_s1 && (!valid_s2 || out_ready);
	assign take_ok = !busy_s1 || (adv && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1  <= 1'b0;
			rem_s1   <= 2'd0;
			valid_s2 <= 1'b0;
		end else begin
			if (load) begin
				busy_s1 <= 1'b1;
				rem_s1  <= seq.len_m1;
			end else if (adv) begin
				busy_s1 <= !last;
				rem_s1  <= rem_s1 - 2'd1;
			end
			if (adv)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			chars_s1 <= seq.chars;
			fin_s1   <= seq.fin;
		end else if (adv) begin
			chars_s1[SEQ_LEN-2:0]   <= chars_s1[SEQ_LEN-1:1];
			chars_s1[SEQ_LEN-1]     <= CHAR_NONE;
		end
		if (adv) begin
			beat_s2.out_byte   <= chars_s1[0];
			beat_s2.run_last   <= last;
			beat_s2.string_end <= last && fin_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_beat  = beat_s2;

	assign stat.busy     = busy_s1;
	assign stat.rem      = rem_s1;
	assign stat.out_full = valid_s2;

endmodule

// ----- hdl/c_string_byte_escaper.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// c_string_byte_escaper
// C-style string escaper: one source byte in, its escaped form out one
// byte per transaction.
// ---------------------------------------------------------------------------
// A byte whose pass-mask bit is set is copied (1 output byte); otherwise
// backspace, form feed, newline, carriage return, tab, backslash and double
// quote become a two-byte escape and every other byte becomes a backslash
// plus three octal digits (4 output bytes). Output runs at one byte per
// cycle unless out_ready stalls it, and a new source byte is taken in
// the same cycle that the previous one's last output byte moves to the
// output register; the single output shifter sets the rate. An accepted
// source byte goes into the sequence register, then its first output
// byte to the output register. run_last marks the final output byte of each
// source byte; string_end also marks it for a final_byte source byte.
// The mask resets to printable ASCII minus double quote and backslash and
// must only be rewritten while the block is idle; writes to indexes above
// three are dropped.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module c_string_byte_escaper
	import cbe_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	cbe_in_if.sink                in_ch,
	cbe_out_if.source             out_ch
);

	logic      pass;
	seq_t      seq;
	logic      take_ok;
	logic      in_xact;
	beat_t     beat;
	ser_stat_t stat;

	// Mask lookup runs straight off the input port byte.
	cbe_mask_regs u_mask (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.lookup_byte (in_ch.in_byte),
		.pass        (pass)
	);

	cbe_encode u_encode (
		.in_byte    (in_ch.in_byte),
		.final_byte (in_ch.final_byte),
		.pass       (pass),
		.seq        (seq)
	);

	// Input transaction loads the sequence register directly.
	assign in_ch.ready = take_ok;
	assign in_xact     = in_ch.valid && take_ok;

	cbe_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (in_xact),
		.seq       (seq),
		.take_ok   (take_ok),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_beat  (beat),
		.stat      (stat)
	);

	assign out_ch.out_byte   = beat.out_byte;
	assign out_ch.run_last   = beat.run_last;
	assign out_ch.string_end = beat.string_end;

	// Checks
	`ASSERT_CLK(a_end_is_last, !(out_ch.valid && out_ch.string_end) || out_ch.run_last, "string_end without run_last")
	`ASSERT_NEXT(a_load_busy, in_xact, stat.busy, "sequence register empty after input transaction")
	`ASSERT_CLK(a_ready_on_last, !(stat.busy && in_ch.ready) || (stat.rem == 2'd0), "ready while sequence has more than one byte left")
	`ASSERT_NEXT(a_octal_len, in_xact && !pass && (short_escape(in_ch.in_byte) == CHAR_NONE), stat.rem == LEN_OCTAL, "octal escape not four bytes")

endmodule
